// File: rtl/swl_pkg.sv
// Shared types, constants and helpers for the stopwatch with laps and warning.
package swl_pkg;

    localparam int MAX_LAPS = 20;
    localparam int CNT_W    = $clog2(MAX_LAPS + 1);
    localparam int LAP_AW   = (MAX_LAPS > 1) ? $clog2(MAX_LAPS) : 1;

    localparam logic [31:0] MS_PER_HOUR = 32'd3600000;
    localparam logic [31:0] MS_PER_MIN  = 32'd60000;
    localparam logic [31:0] MS_PER_SEC  = 32'd1000;
    localparam logic [31:0] WARN_RESET  = 32'd25000;
    localparam logic [15:0] WINDOW_RESET = 16'd5000;

    localparam int HUND_PER_SEC = 100;
    localparam int SEC_PER_MIN  = 60;
    localparam int HOUR_PER_DAY = 24;

    // reciprocal multipliers for exact division of 32-bit values by constants
    localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
    localparam int          SH10     = 35;
    localparam logic [31:0] RECIP100 = 32'h51EB_851F;
    localparam int          SH100    = 37;
    localparam logic [31:0] RECIP60  = 32'h8888_8889;
    localparam int          SH60     = 37;
    localparam logic [31:0] RECIP24  = 32'hAAAA_AAAB;
    localparam int          SH24     = 36;

    typedef enum logic [3:0] {
        OP_TICK      = 4'd0,
        OP_RUN       = 4'd1,
        OP_CLEAR     = 4'd2,
        OP_LAP       = 4'd3,
        OP_WARN_UP_H = 4'd4,
        OP_WARN_DN_H = 4'd5,
        OP_WARN_UP_M = 4'd6,
        OP_WARN_DN_M = 4'd7,
        OP_WARN_UP_S = 4'd8,
        OP_WARN_DN_S = 4'd9,
        OP_READ      = 4'd10
    } swl_op_t;

    // state after one command, handed to the formatter
    typedef struct packed {
        logic        lap_valid;
        logic [31:0] lap_value;
        logic        laps_full;
        logic [4:0]  lap_count;
        logic [31:0] warning_ms;
        logic [31:0] total_ms;
        logic        running;
    } swl_snap_t;

    // result beat, first field in the highest bits
    typedef struct packed {
        logic        lap_valid;
        logic [31:0] lap_value;
        logic        laps_full;
        logic [4:0]  lap_count;
        logic        warning_active;
        logic [31:0] warning_ms;
        logic [6:0]  hundredths;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [31:0] total_ms;
        logic        running;
    } swl_result_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// File: rtl/swl_fmt.sv
// Result formatter: warning window compare and time split into h/m/s/hundredths.
module swl_fmt
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  swl_pkg::swl_snap_t   in_snap,
    input  logic [15:0]          window,
    output logic                 out_valid,
    input  logic                 out_ready,
    output swl_pkg::swl_result_t out_res
);

    localparam int NSTG = 6;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] rdy;

    swl_pkg::swl_result_t st1_res_reg, st2_res_reg, st3_res_reg, st4_res_reg, st5_res_reg;
    swl_pkg::swl_result_t out_res_reg;
    swl_pkg::swl_result_t st1_res_next;
    swl_pkg::swl_result_t st3_res_next, st4_res_next, st5_res_next, out_res_next;

    logic [28:0] st1_q10_reg, st2_q10_reg;
    logic [22:0] st2_d_reg, st3_d_reg;
    logic [16:0] st3_e_reg, st4_e_reg;
    logic [10:0] st4_f_reg, st5_f_reg;
    logic [5:0]  st5_g_reg;

    logic [31:0] win_end;
    logic [63:0] p10, p100, p60a, p60b, p24;
    logic [28:0] q10_next;
    logic [22:0] d_next;
    logic [16:0] e_next;
    logic [10:0] f_next;
    logic [5:0]  g_next;
    logic [6:0]  hund_next;
    logic [5:0]  sec_next;
    logic [5:0]  min_next;
    logic [4:0]  hour_next;

    // stage handshake: a stage loads when empty or when its content moves on
    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next = vld_reg;
        if (rdy[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < NSTG; k++)
        begin
            if (rdy[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        win_end = swl_pkg::sat_add32(in_snap.warning_ms, 32'(window));
        p10     = 64'(in_snap.total_ms) * 64'(swl_pkg::RECIP10);
        q10_next = 29'(p10 >> swl_pkg::SH10);

        st1_res_next                = '0;
        st1_res_next.running        = in_snap.running;
        st1_res_next.total_ms       = in_snap.total_ms;
        st1_res_next.warning_ms     = in_snap.warning_ms;
        st1_res_next.warning_active = (in_snap.total_ms > in_snap.warning_ms)
                                      && (in_snap.total_ms < win_end);
        st1_res_next.lap_count      = in_snap.lap_count;
        st1_res_next.laps_full      = in_snap.laps_full;
        st1_res_next.lap_value      = in_snap.lap_value;
        st1_res_next.lap_valid      = in_snap.lap_valid;

        p100   = 64'(st1_q10_reg) * 64'(swl_pkg::RECIP100);
        d_next = 23'(p100 >> swl_pkg::SH100);

        hund_next = 7'(st2_q10_reg - 29'(st2_d_reg) * 29'(swl_pkg::HUND_PER_SEC));
        p60a      = 64'(st2_d_reg) * 64'(swl_pkg::RECIP60);
        e_next    = 17'(p60a >> swl_pkg::SH60);

        sec_next = 6'(st3_d_reg - 23'(st3_e_reg) * 23'(swl_pkg::SEC_PER_MIN));
        p60b     = 64'(st3_e_reg) * 64'(swl_pkg::RECIP60);
        f_next   = 11'(p60b >> swl_pkg::SH60);

        min_next = 6'(st4_e_reg - 17'(st4_f_reg) * 17'(swl_pkg::SEC_PER_MIN));
        p24      = 64'(st4_f_reg) * 64'(swl_pkg::RECIP24);
        g_next   = 6'(p24 >> swl_pkg::SH24);

        hour_next = 5'(st5_f_reg - 11'(st5_g_reg) * 11'(swl_pkg::HOUR_PER_DAY));

        st3_res_next            = st2_res_reg;
        st3_res_next.hundredths = hund_next;
        st4_res_next            = st3_res_reg;
        st4_res_next.seconds    = sec_next;
        st5_res_next            = st4_res_reg;
        st5_res_next.minutes    = min_next;
        out_res_next            = st5_res_reg;
        out_res_next.hours      = hour_next;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            st1_res_reg <= st1_res_next;
            st1_q10_reg <= q10_next;
        end
        if (rdy[1])
        begin
            st2_res_reg <= st1_res_reg;
            st2_q10_reg <= st1_q10_reg;
            st2_d_reg   <= d_next;
        end
        if (rdy[2])
        begin
            st3_res_reg <= st3_res_next;
            st3_d_reg   <= st2_d_reg;
            st3_e_reg   <= e_next;
        end
        if (rdy[3])
        begin
            st4_res_reg <= st4_res_next;
            st4_e_reg   <= st3_e_reg;
            st4_f_reg   <= f_next;
        end
        if (rdy[4])
        begin
            st5_res_reg <= st5_res_next;
            st5_f_reg   <= st4_f_reg;
            st5_g_reg   <= g_next;
        end
        if (rdy[5])
        begin
            out_res_reg <= out_res_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_res   = out_res_reg;

    a_time_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_res.hours < 5'(swl_pkg::HOUR_PER_DAY))
                   && (out_res.minutes < 6'(swl_pkg::SEC_PER_MIN))
                   && (out_res.seconds < 6'(swl_pkg::SEC_PER_MIN))
                   && (out_res.hundredths < 7'(swl_pkg::HUND_PER_SEC)))
        else $error("time split out of range");

    a_stalled_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_res))
        else $error("stalled result changed");

    a_lap_value_zero_unless_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_res.lap_valid |-> (out_res.lap_value == '0))
        else $error("lap value without a valid read");

endmodule

// File: rtl/stopwatch_with_laps_and_warning_unit.sv
// Stopwatch with lap store and warning window: command decode, state and lap memory.
// One command beat is taken per clock unless the last accepted beat still waits on the formatter;
// every beat gives one result beat (the accepting edge updates the state and reads the lap store,
// then the beat moves through the formatter stages, which split the total into hours,
// minutes, seconds and hundredths by a chain of reciprocal multiplies). The
// stages stall independently, so commands keep flowing into empty stages while a result waits
// on m_tready. The lap store holds 20 entries and is not cleared by reset; only written
// entries are ever read. warn_window_ms may be written only while no result is outstanding.
module stopwatch_with_laps_and_warning_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,     // warn_window_ms
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,       // elapsed_ms[15:0], lap_index[20:16], zero pad
    input  logic [3:0]   s_tuser,       // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata        // running, total_ms, hours, minutes, seconds,
                                        // hundredths, warning_ms, warning_active, lap_count,
                                        // laps_full, lap_value, lap_valid, zero pad
);

    logic                       run_reg, run_next;
    logic [31:0]                total_reg, total_next;
    logic [31:0]                warn_reg, warn_next;
    logic [swl_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]                window_reg;
    logic                       a_vld_reg, a_vld_next;
    swl_pkg::swl_snap_t         snap_reg, snap_next, fmt_snap;
    logic [31:0]                lap_rd_reg;
    logic [31:0]                lap_mem [swl_pkg::MAX_LAPS];

    logic                       accept;
    logic                       fmt_rdy;
    logic                       lap_wr;
    logic                       rd_ok;
    logic                       not_full;
    swl_pkg::swl_op_t           op;
    logic [15:0]                elapsed;
    logic [4:0]                 idx;
    swl_pkg::swl_result_t       res;

    assign op      = swl_pkg::swl_op_t'(s_tuser);
    assign elapsed = s_tdata[15:0];
    assign idx     = s_tdata[20:16];

    assign s_tready = !a_vld_reg || fmt_rdy;
    assign accept   = s_tvalid && s_tready;
    assign not_full = cnt_reg < swl_pkg::CNT_W'(swl_pkg::MAX_LAPS);
    assign lap_wr   = accept && (op == swl_pkg::OP_LAP) && not_full;
    assign rd_ok    = (op == swl_pkg::OP_READ) && (6'(idx) < 6'(cnt_reg));

    always_comb
    begin
        run_next   = run_reg;
        total_next = total_reg;
        warn_next  = warn_reg;
        cnt_next   = cnt_reg;
        case (op)
            swl_pkg::OP_TICK:
            begin
                if (run_reg)
                begin
                    total_next = swl_pkg::sat_add32(total_reg, 32'(elapsed));
                end
            end
            swl_pkg::OP_RUN:
            begin
                run_next = !run_reg;
            end
            swl_pkg::OP_CLEAR:
            begin
                run_next   = 1'b0;
                total_next = '0;
                cnt_next   = '0;
            end
            swl_pkg::OP_LAP:
            begin
                if (not_full)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            swl_pkg::OP_WARN_UP_H: warn_next = swl_pkg::sat_add32(warn_reg, swl_pkg::MS_PER_HOUR);
            swl_pkg::OP_WARN_DN_H:
            begin
                if (warn_reg > swl_pkg::MS_PER_HOUR)
                begin
                    warn_next = warn_reg - swl_pkg::MS_PER_HOUR;
                end
            end
            swl_pkg::OP_WARN_UP_M: warn_next = swl_pkg::sat_add32(warn_reg, swl_pkg::MS_PER_MIN);
            swl_pkg::OP_WARN_DN_M:
            begin
                if (warn_reg > swl_pkg::MS_PER_MIN)
                begin
                    warn_next = warn_reg - swl_pkg::MS_PER_MIN;
                end
            end
            swl_pkg::OP_WARN_UP_S: warn_next = swl_pkg::sat_add32(warn_reg, swl_pkg::MS_PER_SEC);
            swl_pkg::OP_WARN_DN_S:
            begin
                if (warn_reg > swl_pkg::MS_PER_SEC)
                begin
                    warn_next = warn_reg - swl_pkg::MS_PER_SEC;
                end
            end
            default:
            begin
            end
        endcase

        snap_next            = '0;
        snap_next.running    = run_next;
        snap_next.total_ms   = total_next;
        snap_next.warning_ms = warn_next;
        snap_next.lap_count  = 5'(cnt_next);
        snap_next.laps_full  = (cnt_next >= swl_pkg::CNT_W'(swl_pkg::MAX_LAPS));
        snap_next.lap_valid  = rd_ok;

        a_vld_next = accept ? 1'b1 : (fmt_rdy ? 1'b0 : a_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            total_reg  <= '0;
            warn_reg   <= swl_pkg::WARN_RESET;
            cnt_reg    <= '0;
            window_reg <= swl_pkg::WINDOW_RESET;
            a_vld_reg  <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
            if (accept)
            begin
                run_reg   <= run_next;
                total_reg <= total_next;
                warn_reg  <= warn_next;
                cnt_reg   <= cnt_next;
            end
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            snap_reg   <= snap_next;
            lap_rd_reg <= rd_ok ? lap_mem[idx[swl_pkg::LAP_AW-1:0]] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lap_wr)
        begin
            lap_mem[cnt_reg[swl_pkg::LAP_AW-1:0]] <= total_reg;
        end
    end

    always_comb
    begin
        fmt_snap           = snap_reg;
        fmt_snap.lap_value = lap_rd_reg;
    end

    swl_fmt u_fmt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_vld_reg),
        .in_ready  (fmt_rdy),
        .in_snap   (fmt_snap),
        .window    (window_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {7'b0, res};

    a_lap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= swl_pkg::CNT_W'(swl_pkg::MAX_LAPS))
        else $error("lap count above store depth");

    a_paused_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == swl_pkg::OP_TICK) && !run_reg |=> $stable(total_reg))
        else $error("total moved while paused");

    a_clear_effect: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == swl_pkg::OP_CLEAR) |=> (total_reg == '0) && !run_reg
                                               && (cnt_reg == '0) && $stable(warn_reg))
        else $error("clear command left state behind");

endmodule
